// ----- sv/motion_spike_protect_monitor_assert.svh -----
// Assertion macros for the motion spike protect monitor.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef MOTION_SPIKE_PROTECT_MONITOR_ASSERT_SVH
`define MOTION_SPIKE_PROTECT_MONITOR_ASSERT_SVH

// Checked property, ignored while reset is high.
`define MSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define MSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/msp_pkg.sv -----
// Package for the motion spike protect monitor: field widths, event codes,
// register indexes and the result record. No dependencies.
`timescale 1ns / 1ps

package msp_pkg;

  localparam int AccelW = 16;
  localparam int TimeW = 32;
  localparam int CountW = 5;
  localparam int DsqW = 34;
  localparam int CooldownW = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 34;
  localparam int InDataW = 80;
  localparam int OutDataW = 40;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW = 2;
  localparam int FifoCntW = 3;

  localparam logic [DsqW-1:0] ThresholdSqReset = 34'd2056356;
  localparam logic [CountW-1:0] SpikeLimitReset = 5'd3;
  localparam logic [CooldownW-1:0] CooldownReset = 16'd600;
  localparam logic [CountW-1:0] CountMax = 5'd31;

  localparam logic [CfgIdxW-1:0] RegThresholdSq = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSpikeLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCooldownMs = 2'd2;

  typedef enum logic [1:0] {
    EV_SPIKE  = 2'd0,
    EV_ENTER  = 2'd1,
    EV_ACTIVE = 2'd2,
    EV_RESET  = 2'd3
  } event_code_t;

  typedef struct packed {
    event_code_t         code;
    logic                last;
    logic [DsqW-1:0]     dsq;
    logic                protect;
    logic [CountW-1:0]   total;
  } out_item_t;

endpackage

// ----- sv/motion_spike_protect_monitor.sv -----
// Motion spike protect monitor top level: input register, combinational spike
// evaluation and a four-entry result queue. Depends on msp_pkg and the assert header.
`timescale 1ns / 1ps
`include "motion_spike_protect_monitor_assert.svh"
//
// Channel   | Dir | Transfer contents
// s_axis    | in  | tuser: kind; tdata: accel_x, accel_y, accel_z, time_ms
// m_axis    | out | tuser: event_code; tdata: spike_total, protect_on, delta_sq; tlast
// cfg       | in  | cfg_we, cfg_index, cfg_data (write only)
//
// An input transfer is registered when taken and evaluated once the result queue has
// two free entries; its one or two results then queue up behind any earlier ones on m_axis.
// One item is taken every cycle as long as the result queue has two free entries.
// Reset clears the control and history state and loads the register defaults; no clearing pass.
// A stalled m_axis fills the queue and then holds s_axis_tready low.

module motion_spike_protect_monitor
  import msp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], time_ms[79:48]
  input  logic [InDataW-1:0]   s_axis_tdata,
  // kind[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // spike_total[4:0], protect_on[5], delta_sq[39:6]
  output logic [OutDataW-1:0]  m_axis_tdata,
  // event_code[1:0]
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  logic [DsqW-1:0]        threshold_sq;
  logic [CountW-1:0]      spike_limit;
  logic [CooldownW-1:0]   cooldown_ms;

  logic                   s1_valid;
  logic                   s1_kind;
  logic signed [AccelW-1:0] s1_x, s1_y, s1_z;
  logic [TimeW-1:0]       s1_time;

  logic signed [AccelW-1:0] prev_x, prev_y, prev_z;
  logic                   have_prev;
  logic [TimeW-1:0]       last_spike_ms;
  logic [CountW-1:0]      spike_count;
  logic                   guard_mode;

  out_item_t              fifo [FifoDepth];
  logic [FifoPtrW-1:0]    rd_ptr, wr_ptr;
  logic [FifoCntW-1:0]    fifo_count;

  logic                   fire, s_accept, m_accept;
  logic signed [AccelW:0] dx, dy, dz;
  logic [AccelW-1:0]      adx, ady, adz;
  logic [2*AccelW-1:0]    sqx, sqy, sqz;
  logic [DsqW-1:0]        dsq;
  logic [TimeW-1:0]       elapsed;
  logic                   spike, enter;
  logic [CountW-1:0]      cnt_inc;
  logic                   push0, push1;
  out_item_t              item0, item1;

  assign fire = s1_valid && (fifo_count <= FifoCntW'(FifoDepth - 2));
  assign s_axis_tready = !s1_valid || fire;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fifo_count != '0);
  assign m_accept = m_axis_tvalid && m_axis_tready;

  assign m_axis_tdata = {fifo[rd_ptr].dsq, fifo[rd_ptr].protect, fifo[rd_ptr].total};
  assign m_axis_tuser = fifo[rd_ptr].code;
  assign m_axis_tlast = fifo[rd_ptr].last;

  always_comb begin
    dx = {s1_x[AccelW-1], s1_x} - {prev_x[AccelW-1], prev_x};
    dy = {s1_y[AccelW-1], s1_y} - {prev_y[AccelW-1], prev_y};
    dz = {s1_z[AccelW-1], s1_z} - {prev_z[AccelW-1], prev_z};
    adx = dx[AccelW] ? AccelW'(-dx) : dx[AccelW-1:0];
    ady = dy[AccelW] ? AccelW'(-dy) : dy[AccelW-1:0];
    adz = dz[AccelW] ? AccelW'(-dz) : dz[AccelW-1:0];
    sqx = {{AccelW{1'b0}}, adx} * {{AccelW{1'b0}}, adx};
    sqy = {{AccelW{1'b0}}, ady} * {{AccelW{1'b0}}, ady};
    sqz = {{AccelW{1'b0}}, adz} * {{AccelW{1'b0}}, adz};
    dsq = DsqW'(sqx) + DsqW'(sqy) + DsqW'(sqz);
    elapsed = s1_time - last_spike_ms;
    spike = have_prev && (dsq >= threshold_sq) &&
            (elapsed >= {{(TimeW-CooldownW){1'b0}}, cooldown_ms});
    cnt_inc = (spike_count != CountMax) ? spike_count + CountW'(1) : spike_count;
    enter = !guard_mode && (cnt_inc >= spike_limit);
  end

  always_comb begin
    push0 = 1'b0;
    push1 = 1'b0;
    item0 = '{code: EV_RESET, last: 1'b1, dsq: '0, protect: 1'b0, total: '0};
    item1 = '{code: EV_ENTER, last: 1'b1, dsq: dsq, protect: 1'b1, total: cnt_inc};
    if (fire) begin
      if (s1_kind) begin
        push0 = 1'b1;
      end else if (spike) begin
        push0 = 1'b1;
        if (guard_mode) begin
          item0 = '{code: EV_ACTIVE, last: 1'b1, dsq: dsq, protect: 1'b1,
                    total: spike_count};
        end else begin
          item0 = '{code: EV_SPIKE, last: !enter, dsq: dsq, protect: enter,
                    total: cnt_inc};
          push1 = enter;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_sq <= ThresholdSqReset;
      spike_limit <= SpikeLimitReset;
      cooldown_ms <= CooldownReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegThresholdSq: threshold_sq <= cfg_data;
        RegSpikeLimit:  spike_limit <= cfg_data[CountW-1:0];
        RegCooldownMs:  cooldown_ms <= cfg_data[CooldownW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_kind <= s_axis_tuser;
      s1_x <= s_axis_tdata[15:0];
      s1_y <= s_axis_tdata[31:16];
      s1_z <= s_axis_tdata[47:32];
      s1_time <= s_axis_tdata[79:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      prev_z <= '0;
      have_prev <= 1'b0;
      last_spike_ms <= '0;
      spike_count <= '0;
      guard_mode <= 1'b0;
    end else if (fire) begin
      if (s1_kind) begin
        spike_count <= '0;
        guard_mode <= 1'b0;
      end else begin
        prev_x <= s1_x;
        prev_y <= s1_y;
        prev_z <= s1_z;
        have_prev <= 1'b1;
        if (spike) begin
          last_spike_ms <= s1_time;
          if (!guard_mode) begin
            spike_count <= cnt_inc;
            guard_mode <= enter;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo[wr_ptr] <= item0;
    end
    if (push1) begin
      fifo[wr_ptr + FifoPtrW'(1)] <= item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr <= wr_ptr + FifoPtrW'(push0) + FifoPtrW'(push1);
      rd_ptr <= rd_ptr + FifoPtrW'(m_accept);
      fifo_count <= fifo_count + FifoCntW'(push0) + FifoCntW'(push1)
                    - FifoCntW'(m_accept);
    end
  end

  `MSP_ASSERT(a_fifo_bound, fifo_count <= FifoCntW'(FifoDepth), "result queue overflow")
  `MSP_ASSERT(a_enter_sets_mode, fire && !s1_kind && spike && enter |=> guard_mode, "no protect")
  `MSP_ASSERT(a_reset_clears, fire && s1_kind |=> spike_count == '0 && !guard_mode, "clear failed")
  `MSP_ASSERT_ALWAYS(a_pair_only_on_enter, push1 |-> push0 && enter, "unpaired result")

endmodule

// ----- tb/sv/tb_motion_spike_protect_monitor.sv -----
`timescale 1ns / 1ps
// Testbench for motion_spike_protect_monitor. A directed table is followed by random phases
// under several register settings, and every result is checked against a spike predictor.
// Depends on msp_pkg and the monitor RTL only.

module tb_motion_spike_protect_monitor;
  import msp_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int StallLimit = 5000;
  localparam int DrainCycles = 4;
  localparam int HoldCycles = 120;

  typedef struct packed {
    logic              kind;
    logic [AccelW-1:0] ax, ay, az;
    logic [TimeW-1:0]  ms;
    logic              typed;
    logic [1:0]        n;
    event_code_t       code;
    logic [CountW-1:0] total;
    logic              prot;
    logic [DsqW-1:0]   dsq;
  } plan_row_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [InDataW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  logic [DsqW-1:0] thr_sq;
  logic [CountW-1:0] limit_n;
  logic [CooldownW-1:0] cool_ms;
  logic signed [AccelW-1:0] last_x, last_y, last_z;
  logic seen_sample;
  logic [TimeW-1:0] spike_stamp;
  logic [CountW-1:0] spike_tally;
  logic guard_on;
  out_item_t awaited[$];

  int fail_count;
  int idle_cycles;
  bit quiet;
  bit hold_outputs;
  logic [TimeW-1:0] sim_ms;
  logic [AccelW-1:0] pos_x, pos_y, pos_z;

  plan_row_t plan [16] = '{
    '{1'b0, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b1, 2'd0, EV_SPIKE, 5'd0, 1'b0, 34'd0},
    '{1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd100, 1'b1, 2'd0, EV_SPIKE, 5'd0, 1'b0, 34'd0},
    '{1'b0, 16'h8000, 16'h8000, 16'h8000, 32'd600, 1'b1, 2'd1, EV_SPIKE, 5'd1, 1'b0,
      34'd12884508675},
    '{1'b0, 16'h8000, 16'h8000, 16'h8000, 32'd1300, 1'b1, 2'd0, EV_SPIKE, 5'd0, 1'b0, 34'd0},
    '{1'b0, -16'sd31334, 16'h8000, 16'h8000, 32'd2000, 1'b1, 2'd1, EV_SPIKE, 5'd2, 1'b0,
      34'd2056356},
    '{1'b0, -16'sd29901, 16'h8000, 16'h8000, 32'd3000, 1'b1, 2'd0, EV_SPIKE, 5'd0, 1'b0, 34'd0},
    '{1'b0, -16'sd28467, 16'h8000, 16'h8000, 32'd3599, 1'b1, 2'd2, EV_SPIKE, 5'd3, 1'b1,
      34'd2056356},
    '{1'b0, -16'sd29901, 16'h8000, 16'h8000, 32'd4199, 1'b1, 2'd1, EV_ACTIVE, 5'd3, 1'b1,
      34'd2056356},
    '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 2'd1, EV_RESET, 5'd0, 1'b0,
      34'd0},
    '{1'b0, -16'sd28467, 16'h8000, 16'h8000, 32'hFFFF_FF00, 1'b1, 2'd1, EV_SPIKE, 5'd1, 1'b0,
      34'd2056356},
    '{1'b0, -16'sd29901, 16'h8000, 16'h8000, 32'h0000_0100, 1'b1, 2'd0, EV_SPIKE, 5'd0, 1'b0,
      34'd0},
    '{1'b0, -16'sd28467, 16'h8000, 16'h8000, 32'h0000_0158, 1'b1, 2'd1, EV_SPIKE, 5'd2, 1'b0,
      34'd2056356},
    '{1'b0, 16'h7FFF, 16'h8000, 16'd12345, 32'h0001_0000, 1'b0, 2'd0, EV_SPIKE, 5'd0, 1'b0,
      34'd0},
    '{1'b0, 16'hFFFF, 16'h0001, 16'hFFFF, 32'h8000_0000, 1'b0, 2'd0, EV_SPIKE, 5'd0, 1'b0,
      34'd0},
    '{1'b0, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0, 2'd0, EV_SPIKE, 5'd0, 1'b0,
      34'd0},
    '{1'b1, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b1, 2'd1, EV_RESET, 5'd0, 1'b0, 34'd0}
  };

  motion_spike_protect_monitor u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic void queue_event(input event_code_t code, input logic [DsqW-1:0] dsq,
                                      input logic last);
    out_item_t ev;
    ev.code = code;
    ev.last = last;
    ev.dsq = dsq;
    ev.protect = guard_on;
    ev.total = spike_tally;
    awaited.push_back(ev);
  endfunction

  task automatic predict_events(input logic kind, input logic [InDataW-1:0] data,
                                output int n);
    logic signed [AccelW-1:0] ax, ay, az;
    logic [TimeW-1:0] now, elapsed;
    longint dx, dy, dz;
    logic [DsqW-1:0] dsq;
    ax = data[AccelW-1:0];
    ay = data[2*AccelW-1:AccelW];
    az = data[3*AccelW-1:2*AccelW];
    now = data[InDataW-1:3*AccelW];
    n = 0;
    if (kind) begin
      spike_tally = '0;
      guard_on = 1'b0;
      queue_event(EV_RESET, '0, 1'b1);
      n = 1;
    end else begin
      dx = longint'(ax) - longint'(last_x);
      dy = longint'(ay) - longint'(last_y);
      dz = longint'(az) - longint'(last_z);
      dsq = DsqW'(dx * dx + dy * dy + dz * dz);
      elapsed = now - spike_stamp;
      if (seen_sample && dsq >= thr_sq && elapsed >= TimeW'(cool_ms)) begin
        spike_stamp = now;
        if (!guard_on) begin
          if (spike_tally != CountMax) spike_tally = spike_tally + 1'b1;
          if (spike_tally >= limit_n) begin
            guard_on = 1'b1;
            queue_event(EV_SPIKE, dsq, 1'b0);
            queue_event(EV_ENTER, dsq, 1'b1);
            n = 2;
          end else begin
            queue_event(EV_SPIKE, dsq, 1'b1);
            n = 1;
          end
        end else begin
          queue_event(EV_ACTIVE, dsq, 1'b1);
          n = 1;
        end
      end
      seen_sample = 1'b1;
      last_x = ax;
      last_y = ay;
      last_z = az;
    end
  endtask

  task automatic push_item(input logic kind, input logic [InDataW-1:0] data, output int n);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_events(kind, data, n);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      RegThresholdSq: thr_sq = value[DsqW-1:0];
      RegSpikeLimit: limit_n = value[CountW-1:0];
      RegCooldownMs: cool_ms = value[CooldownW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic push_random;
    logic kind;
    logic [InDataW-1:0] data;
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    kind = 1'b0;
    if (pick < 5) begin
      kind = 1'b1;
      data = {$urandom, 16'($urandom), $urandom};
    end else if (pick < 15) begin
      data = {$urandom, 16'($urandom), $urandom};
    end else begin
      sim_ms = sim_ms + $urandom_range(0, 2 * int'(cool_ms) + 20);
      if ($urandom_range(0, 2) == 0) begin
        pos_x = pos_x + 16'($urandom_range(0, 8000)) - 16'd4000;
        pos_y = pos_y + 16'($urandom_range(0, 8000)) - 16'd4000;
        pos_z = pos_z + 16'($urandom_range(0, 8000)) - 16'd4000;
      end else begin
        pos_x = pos_x + 16'($urandom_range(0, 128)) - 16'd64;
        pos_y = pos_y + 16'($urandom_range(0, 128)) - 16'd64;
        pos_z = pos_z + 16'($urandom_range(0, 128)) - 16'd64;
      end
      data = {sim_ms, pos_z, pos_y, pos_x};
    end
    push_item(kind, data, n);
  endtask

  task automatic run_phase(input logic [DsqW-1:0] thr, input logic [CountW-1:0] lim,
                           input logic [CooldownW-1:0] cool, input bit poke_unused,
                           input bit long_hold, input int count);
    int n;
    drain();
    write_reg(RegThresholdSq, thr);
    write_reg(RegSpikeLimit, lim);
    write_reg(RegCooldownMs, cool);
    if (poke_unused) write_reg(RegUnused, '1);
    cfg_we <= 1'b0;
    push_item(1'b1, {$urandom, 16'($urandom), $urandom}, n);
    if (long_hold) hold_outputs = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (!quiet && (i == count / 2 || $urandom_range(0, 59) == 0)) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (awaited.size() != 0);
      end
      push_random();
    end
  endtask

  initial begin : sink
    int stall;
    forever begin
      if (hold_outputs) begin
        stall = HoldCycles;
        hold_outputs = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        stall = $urandom_range(1, 15);
      end else begin
        stall = 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result code %0d total %0d",
                                  m_axis_tuser, m_axis_tdata[CountW-1:0]));
      end else begin
        want = awaited.pop_front();
        if (m_axis_tuser !== want.code || m_axis_tdata[CountW-1:0] !== want.total ||
            m_axis_tdata[CountW] !== want.protect ||
            m_axis_tdata[CountW+DsqW:CountW+1] !== want.dsq || m_axis_tlast !== want.last) begin
          report_mismatch($sformatf(
            "got code %0d total %0d protect %0b dsq %0d last %0b, want %0d %0d %0b %0d %0b",
            m_axis_tuser, m_axis_tdata[CountW-1:0], m_axis_tdata[CountW],
            m_axis_tdata[CountW+DsqW:CountW+1], m_axis_tlast,
            want.code, want.total, want.protect, want.dsq, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t row;
    out_item_t lead;
    int n;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser <= 1'b0;
    s_axis_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    fail_count = 0;
    idle_cycles = 0;
    thr_sq = ThresholdSqReset;
    limit_n = SpikeLimitReset;
    cool_ms = CooldownReset;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    seen_sample = 1'b0;
    spike_stamp = '0;
    spike_tally = '0;
    guard_on = 1'b0;
    sim_ms = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      push_item(row.kind, {row.ms, row.az, row.ay, row.ax}, n);
      if (row.typed && n != int'(row.n)) begin
        report_mismatch($sformatf("row %0d: %0d results predicted, table has %0d",
                                  i, n, row.n));
      end else if (row.typed && n > 0) begin
        lead = awaited[awaited.size() - n];
        if (lead.code != row.code || lead.total != row.total ||
            lead.protect != row.prot || lead.dsq != row.dsq) begin
          report_mismatch($sformatf("row %0d: predicted code %0d total %0d dsq %0d",
                                    i, lead.code, lead.total, lead.dsq));
        end
      end
    end

    run_phase('0, 5'd0, 16'd0, 1'b0, 1'b1, 60);
    run_phase('1, 5'd31, 16'hFFFF, 1'b1, 1'b0, 30);
    run_phase(DsqW'($urandom_range(0, 1 << 22)), 5'd1, 16'($urandom_range(0, 300)),
              1'b0, 1'b0, 75);
    run_phase(DsqW'($urandom_range(0, 1 << 22)), 5'd20, 16'($urandom_range(0, 300)),
              1'b0, 1'b0, 75);
    run_phase(DsqW'($urandom_range(0, 1 << 22)), 5'($urandom_range(2, 19)),
              16'($urandom_range(0, 2000)), 1'b0, 1'b0, 75);
    quiet = 1'b1;
    run_phase(DsqW'($urandom_range(0, 1 << 22)), 5'($urandom_range(1, 20)),
              16'($urandom_range(0, 300)), 1'b0, 1'b0, 75);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/msp_pkg.sv
sv/motion_spike_protect_monitor.sv
tb/sv/tb_motion_spike_protect_monitor.sv
